/* rtl/sha1bs_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: shared types
// Request and result payloads, the chaining word bundle and the control
// bundle between the byte sequencer and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1bs_pkg;

  // Input request: one message byte plus framing
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha1bs_in_t;

  // Output request: one digest byte
  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } sha1bs_out_t;

  // Five chaining words, index 0 is H0
  typedef logic [4:0][31:0] sha1bs_chain_t;

  // Sequencer to core controls
  typedef struct packed {
    logic       byte_en;  // shift one byte into the block window
    logic [7:0] data;     // byte to shift in
    logic       start;    // start a compression of the window
    logic       init;     // return chaining words to the initial values
  } sha1bs_ctrl_t;

  // Configuration limits
  localparam logic [4:0] DigestBytesReset = 5'd20;
  localparam logic [4:0] DigestBytesMax   = 5'd20;

endpackage

`default_nettype wire

/* rtl/sha1_byte_stream_hash.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash, top level
// Takes message bytes, pads the message, and emits leading digest bytes.
// ----------------------------------------------------------------------------
// Every 64th byte starts a compression that keeps the block busy through
// 80 rounds on the one round adder of the core plus one chaining add. On
// the request marked last the block feeds the padding one byte per cycle up
// to the end of the block (one or two blocks, each followed by its
// compression), then presents the digest bytes one per cycle as the output
// side takes them. Input stall stays low while a block fills; it goes high
// after the request that completes a block or ends the message, and stays
// high through the compression, the padding and the digest output. A
// digest_bytes value of zero gives one byte; values above twenty give twenty.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hash (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [4:0]              cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire sha1bs_pkg::sha1bs_in_t  in_req_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output sha1bs_pkg::sha1bs_out_t      out_req_o
);
  import sha1bs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_HASH,
    ST_OUT
  } state_e;

  localparam logic [5:0] PosLast    = 6'd63;
  localparam logic [5:0] PosLenPrev = 6'd55;
  localparam logic [7:0] PadMarker  = 8'h80;

  state_e        state_q, state_d;
  logic [5:0]    pos_q, pos_d;
  logic [63:0]   count_q, count_d;
  logic          fin_q, fin_d;
  logic          first_q, first_d;
  logic          len_q, len_d;
  logic [4:0]    idx_q, idx_d;
  logic [4:0]    dig_q;

  sha1bs_ctrl_t  ctrl;
  sha1bs_chain_t chain;
  logic          core_done;
  logic          in_acc, out_acc;
  logic [7:0]    pad_byte;
  logic [4:0]    last_idx;
  logic [31:0]   out_word;

  sha1bs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .done_o  (core_done),
    .chain_o (chain)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  // Select the padding byte: marker, zero fill, then the bit length
  always_comb begin
    if (first_q) begin
      pad_byte = PadMarker;
    end else if (len_q) begin
      pad_byte = count_q[{~pos_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  // Clamp the digest length to the last byte index
  always_comb begin
    if (dig_q == '0) begin
      last_idx = '0;
    end else if (dig_q > DigestBytesMax) begin
      last_idx = DigestBytesMax - 5'd1;
    end else begin
      last_idx = dig_q - 5'd1;
    end
  end

  // Pick the digest byte, most significant byte of each word first
  always_comb begin
    unique case (idx_q[4:2])
      3'd0:    out_word = chain[0];
      3'd1:    out_word = chain[1];
      3'd2:    out_word = chain[2];
      3'd3:    out_word = chain[3];
      3'd4:    out_word = chain[4];
      default: out_word = '0;
    endcase
    out_req_o.digest_byte = out_word[{~idx_q[1:0], 3'b000} +: 8];
    out_req_o.digest_last = (idx_q == last_idx);
  end

  // Sequence bytes, padding, compressions and digest output
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    count_d = count_q;
    fin_d   = fin_q;
    first_d = first_q;
    len_d   = len_q;
    idx_d   = idx_q;
    ctrl    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          fin_d   = in_req_i.last;
          first_d = in_req_i.last;
          if (in_req_i.has_byte) begin
            ctrl.byte_en = 1'b1;
            ctrl.data    = in_req_i.data_byte;
            pos_d        = pos_q + 6'd1;
            count_d      = count_q + 64'd8;
          end
          if (in_req_i.has_byte && (pos_q == PosLast)) begin
            ctrl.start = 1'b1;
            state_d    = ST_HASH;
          end else if (in_req_i.last) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        ctrl.byte_en = 1'b1;
        ctrl.data    = pad_byte;
        pos_d        = pos_q + 6'd1;
        first_d      = 1'b0;
        if (pos_q == PosLenPrev) begin
          len_d = 1'b1;
        end
        if (pos_q == PosLast) begin
          ctrl.start = 1'b1;
          state_d    = ST_HASH;
        end
      end

      ST_HASH: begin
        if (core_done) begin
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (len_q) begin
            idx_d   = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_PAD;
          end
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          if (idx_q == last_idx) begin
            ctrl.init = 1'b1;
            pos_d     = '0;
            count_d   = '0;
            fin_d     = 1'b0;
            first_d   = 1'b0;
            len_d     = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      fin_q   <= 1'b0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      fin_q   <= fin_d;
      first_q <= first_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  // Digest length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= DigestBytesReset;
    end else if (cfg_we_i) begin
      dig_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/sha1bs_core.sv */
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Holds the 512-bit block window, the working words and the chaining words.
// Bytes shift into the window one at a time; a compression then runs one
// round per cycle through a single round adder, with the message schedule
// produced in place by shifting the window, and a final step adds the
// working words into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bs_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sha1bs_pkg::sha1bs_ctrl_t ctrl_i,
  output logic                          done_o,
  output sha1bs_pkg::sha1bs_chain_t     chain_o
);
  import sha1bs_pkg::*;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam sha1bs_chain_t ChainInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                         32'hEFCDAB89, 32'h67452301};

  localparam logic [6:0] RoundFinal = 7'd80;
  localparam logic [6:0] Phase1     = 7'd20;
  localparam logic [6:0] Phase2     = 7'd40;
  localparam logic [6:0] Phase3     = 7'd60;

  // Block window, word 0 in the top bits
  logic [511:0]  win_q, win_d;
  logic [31:0]   a_q, b_q, c_q, d_q, e_q;
  logic [31:0]   a_d, b_d, c_d, d_d, e_d;
  sha1bs_chain_t h_q, h_d;
  logic          busy_q, busy_d;
  logic [6:0]    round_q, round_d;

  logic [31:0] w0, w2, w8, w13, sched, sched_x;
  logic [31:0] f, k, tmp;
  logic        round_run;

  // Pick the schedule taps and the round function
  always_comb begin
    w0      = win_q[511:480];
    w2      = win_q[447:416];
    w8      = win_q[255:224];
    w13     = win_q[95:64];
    sched_x = w13 ^ w8 ^ w2 ^ w0;
    sched   = {sched_x[30:0], sched_x[31]};

    if (round_q < Phase1) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (round_q < Phase2) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (round_q < Phase3) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end

    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;
  end

  assign round_run = busy_q && (round_q != RoundFinal);
  assign done_o    = busy_q && (round_q == RoundFinal);
  assign chain_o   = h_q;

  // Next state of window, working words and control
  always_comb begin
    win_d   = win_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    h_d     = h_q;
    busy_d  = busy_q;
    round_d = round_q;

    // Shift a new byte in
    if (ctrl_i.byte_en) begin
      win_d = {win_q[503:0], ctrl_i.data};
    end

    // Load working words from the chain
    if (ctrl_i.start) begin
      a_d     = h_q[0];
      b_d     = h_q[1];
      c_d     = h_q[2];
      d_d     = h_q[3];
      e_d     = h_q[4];
      busy_d  = 1'b1;
      round_d = '0;
    end

    // Advance one round
    if (round_run) begin
      win_d   = {win_q[479:0], sched};
      a_d     = tmp;
      b_d     = a_q;
      c_d     = {b_q[1:0], b_q[31:2]};
      d_d     = c_q;
      e_d     = d_q;
      round_d = round_q + 7'd1;
    end

    // Fold the working words into the chain
    if (done_o) begin
      h_d[0] = h_q[0] + a_q;
      h_d[1] = h_q[1] + b_q;
      h_d[2] = h_q[2] + c_q;
      h_d[3] = h_q[3] + d_q;
      h_d[4] = h_q[4] + e_q;
      busy_d = 1'b0;
    end

    if (ctrl_i.init) begin
      h_d = ChainInit;
    end
  end

  // Control and chain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= '0;
      h_q     <= ChainInit;
    end else begin
      busy_q  <= busy_d;
      round_q <= round_d;
      h_q     <= h_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

endmodule

`default_nettype wire

/* bench/sha1bs_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: digest checker
// Watches the request, result and configuration ports, keeps its own SHA-1
// state, queues the digest bytes each accepted request should produce, and
// compares every accepted result against the oldest queued byte.
// ----------------------------------------------------------------------------
module sha1bs_digest_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [4:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  sha1bs_pkg::sha1bs_in_t  in_req_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  sha1bs_pkg::sha1bs_out_t out_req_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);
  import sha1bs_pkg::*;

  localparam sha1bs_chain_t ChainInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                         32'hEFCDAB89, 32'h67452301};
  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadMarker  = 8'h80;
  localparam logic [5:0]  LengthSlot = 6'd56;
  localparam int          ReportLimit = 10;

  sha1bs_chain_t     chain_q;
  logic [15:0][31:0] block_q;
  logic [63:0]       bit_cnt;
  logic [5:0]        byte_pos;
  logic [4:0]        digest_len;
  sha1bs_out_t       digest_q [$];
  sha1bs_out_t       want;
  int                failures = 0;
  int                checked  = 0;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Run the 80 rounds over the block buffer and fold into the chaining words
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < 16; t++) w[t] = block_q[t];
    for (int t = 16; t < 80; t++) w[t] = rotl32(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      sum = rotl32(a, 5) + f + e + k + w[t];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = sum;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
    chain_q[4] = chain_q[4] + e;
  endfunction

  // Place one byte big-endian in the block; compress when the block wraps
  function automatic void absorb_byte(input logic [7:0] value);
    int sh;
    sh = 8 * (3 - int'(byte_pos[1:0]));
    block_q[byte_pos[5:2]][sh +: 8] = value;
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) compress_block();
  endfunction

  function automatic void clear_hash();
    chain_q  = ChainInit;
    block_q  = '0;
    bit_cnt  = '0;
    byte_pos = '0;
  endfunction

  // Absorb one request; on the final one pad, finish and queue the digest bytes
  function automatic void predict_digest(input sha1bs_in_t req);
    logic [63:0] len;
    int          n;
    sha1bs_out_t r;
    if (req.has_byte) begin
      absorb_byte(req.data_byte);
      bit_cnt = bit_cnt + 64'd8;
    end
    if (!req.last) return;
    len = bit_cnt;
    absorb_byte(PadMarker);
    while (byte_pos != LengthSlot) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(len[8*(7-i) +: 8]);
    n = digest_len;
    if (n == 0) n = 1;
    if (n > DigestBytesMax) n = DigestBytesMax;
    for (int i = 0; i < n; i++) begin
      r.digest_byte = chain_q[i / 4][8*(3 - i % 4) +: 8];
      r.digest_last = (i == n - 1);
      digest_q.push_back(r);
    end
    clear_hash();
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_hash();
      digest_len = DigestBytesReset;
      digest_q.delete();
    end else begin
      // latch a new digest length
      if (cfg_we_i) digest_len = cfg_wdata_i;

      // match each accepted digest byte against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (digest_q.size() == 0) begin
          failures++;
          if (failures <= ReportLimit)
            $display("%0t: unexpected digest byte %02h last %0b", $realtime,
                     out_req_i.digest_byte, out_req_i.digest_last);
        end else begin
          want = digest_q.pop_front();
          if (out_req_i.digest_byte !== want.digest_byte ||
              out_req_i.digest_last !== want.digest_last) begin
            failures++;
            if (failures <= ReportLimit)
              $display("%0t: digest mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       $realtime, want.digest_byte, want.digest_last,
                       out_req_i.digest_byte, out_req_i.digest_last);
          end
        end
      end

      // predict the results of each accepted request
      if (in_valid_i && !in_stall_i) predict_digest(in_req_i);
    end
    fail_count_o <= failures;
    pending_o    <= digest_q.size();
    checked_o    <= checked;
  end

endmodule

/* bench/tb_sha1_byte_stream_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: testbench top
// Streams messages of many lengths, padding boundaries among them, under
// bursty requests and an irregular result stall, across several digest
// lengths; the digest checker predicts and compares every result byte.
// ----------------------------------------------------------------------------
module tb_sha1_byte_stream_hash;
  import sha1bs_pkg::*;

  localparam int ClkHalf       = 4;
  localparam int ResetCycles   = 4;
  localparam int RandomItems   = 460;
  localparam int NumPhases     = 8;
  localparam int DrainCycles   = 300;
  localparam int HoldOffCycles = 600;
  localparam int HoldOffAfter  = 80;
  localparam int IdleLimit     = 4000;

  typedef enum logic [1:0] {StallNone, StallRandom, StallAlternate, StallSolid} stall_mode_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [4:0]  cfg_wdata = 5'd0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  sha1bs_in_t  in_req    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sha1bs_out_t out_req;

  int fail_count;
  int pending;
  int checked;
  int burst_left   = 0;
  int items_sent   = 0;
  int messages     = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  always #ClkHalf clk = ~clk;

  sha1_byte_stream_hash dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  sha1bs_digest_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  function automatic sha1bs_in_t byte_req(input logic [7:0] data, input logic has,
                                          input logic fin);
    sha1bs_in_t r;
    r.data_byte = data;
    r.has_byte  = has;
    r.last      = fin;
    return r;
  endfunction

  // Offer one request in bursts separated by random gaps; hold until taken
  task automatic send_item(input sha1bs_in_t req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Send a message of random bytes with occasional empty requests mixed in
  task automatic send_message(input int len, input bit byte_on_last);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(byte_req(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      send_item(byte_req(8'($urandom_range(0, 255)), 1'b1,
                         byte_on_last && (i == len - 1)));
    end
    if (!(byte_on_last && len > 0))
      send_item(byte_req(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    messages++;
  endtask

  // Mostly short messages, a share right at the padding boundaries
  function automatic int pick_message_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 12);
      6, 7, 8: begin
        case ($urandom_range(0, 7))
          0: return 55;
          1: return 56;
          2: return 57;
          3: return 63;
          4: return 64;
          5: return 65;
          6: return 119;
          default: return 120;
        endcase
      end
      default: return $urandom_range(1, 130);
    endcase
  endfunction

  // Drop valid, wait for every expected byte, then let the core go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_digest_len(input logic [4:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Directed: empty message, short text, byte on the final request, extremes
  task automatic send_directed();
    send_item(byte_req(8'h00, 1'b0, 1'b1));
    send_item(byte_req(8'hA5, 1'b0, 1'b0));
    send_item(byte_req(8'hFF, 1'b0, 1'b0));
    send_item(byte_req(8'h61, 1'b1, 1'b0));
    send_item(byte_req(8'h62, 1'b1, 1'b0));
    send_item(byte_req(8'h63, 1'b1, 1'b0));
    send_item(byte_req(8'h00, 1'b0, 1'b1));
    send_item(byte_req(8'hFF, 1'b1, 1'b0));
    send_item(byte_req(8'h00, 1'b1, 1'b0));
    send_item(byte_req(8'h5A, 1'b0, 1'b0));
    send_item(byte_req(8'h7E, 1'b1, 1'b1));
    send_item(byte_req(8'h00, 1'b1, 1'b1));
    send_item(byte_req(8'hFF, 1'b1, 1'b1));
    messages += 5;
  endtask

  // Stimulus: reset, then one digest length per phase
  initial begin : stimulus
    int          target;
    int          room;
    int          msg_len;
    logic [4:0]  setting;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: setting = DigestBytesReset;
        1: setting = 5'd0;
        2: setting = 5'd31;
        3: setting = 5'd1;
        4: setting = 5'd8;
        5: setting = 5'd21;
        6: setting = 5'($urandom_range(2, 19));
        default: setting = DigestBytesMax;
      endcase
      write_digest_len(setting);
      if (p == 0) send_directed();
      // At least one message per setting; clip lengths to the overall budget
      target = RandomItems * (p + 1) / NumPhases;
      do begin
        room    = RandomItems - items_sent - 1;
        msg_len = pick_message_len();
        if (msg_len > room) msg_len = (room > 0) ? room : 0;
        send_message(msg_len, 1'($urandom_range(0, 1)));
      end while (items_sent < target);
    end
    settle();
    $display("covered %0d messages in %0d requests over %0d digest length settings",
             messages, items_sent, NumPhases);
    $display("checked %0d digest bytes, including one long result hold-off", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d digest failures, %0d bytes still expected", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: stall on shifting patterns, once holding off for a long stretch
  initial begin : receiver
    stall_mode_e mode;
    int          span;
    bit          held = 1'b0;
    forever begin
      if (!held && results_seen >= HoldOffAfter) begin
        held = 1'b1;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      span = (mode == StallSolid) ? $urandom_range(1, 12) : $urandom_range(8, 40);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        case (mode)
          StallNone:      out_stall <= 1'b0;
          StallRandom:    out_stall <= 1'($urandom_range(0, 1));
          StallAlternate: out_stall <= i[0];
          default:        out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) results_seen++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("watchdog: no request moved for %0d cycles", IdleLimit);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

endmodule
